// ===== rtl/fdnd_pkg.sv =====
`default_nettype none
package fdnd_pkg;

  localparam int ENTRY_W = 256;
  localparam int POS_W = 9;

  localparam logic [7:0] HEAD_END = 8'h00;
  localparam logic [7:0] HEAD_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN = 8'h0F;
  localparam int ATTR_VOLUME_BIT = 3;
  localparam int ATTR_DIR_BIT = 4;
  localparam int ORD_START_BIT = 6;
  localparam logic [5:0] ORD_MAX = 6'd20;
  localparam logic [3:0] LFN_LAST_CHAR = 4'd12;
  localparam logic [3:0] SUM_LAST_BYTE = 4'd10;
  localparam logic [15:0] CHAR_NUL = 16'h0000;
  localparam logic [15:0] CHAR_PAD = 16'hFFFF;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_DOT = 8'h2E;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

  // Byte offset of each UTF-16 character within a long-name slot.
  function automatic logic [4:0] lfn_off(input logic [3:0] idx);
    logic [4:0] off;
    case (idx)
      4'd0: off = 5'd1;
      4'd1: off = 5'd3;
      4'd2: off = 5'd5;
      4'd3: off = 5'd7;
      4'd4: off = 5'd9;
      4'd5: off = 5'd14;
      4'd6: off = 5'd16;
      4'd7: off = 5'd18;
      4'd8: off = 5'd20;
      4'd9: off = 5'd22;
      4'd10: off = 5'd24;
      4'd11: off = 5'd28;
      4'd12: off = 5'd30;
      default: off = 5'd1;
    endcase
    return off;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE_OFS;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fdnd_ram.sv =====
`default_nettype none
module fdnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/fat_dirent_name_decoder.sv =====
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   four entry words, new_directory flag
// out      output     out_valid/out_stall name chunk, byte count, entry metadata
//
// A deleted, volume or dot entry is dropped after decode; a long-name slot then gathers
// up to 13 characters. A visible entry is decoded and checksummed over 11 bytes, then each
// name byte is fetched and picked (long names via the single name store read port) and
// each chunk is delivered. An end marker is decoded, then gives its result.
// Reset is synchronous and clears the sequencer and the name store valid bits.
// A stalled result holds the sequencer; no new request is taken until the last
// result of the current entry has been delivered.
module fat_dirent_name_decoder #(
  parameter int NAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_entry_bytes_0_7,
  input  wire logic [63:0] in_entry_bytes_8_15,
  input  wire logic [63:0] in_entry_bytes_16_23,
  input  wire logic [63:0] in_entry_bytes_24_31,
  input  wire logic        in_new_directory,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_end_of_directory,
  output logic [63:0]      out_name_chunk,
  output logic [3:0]       out_chunk_bytes,
  output logic             out_name_is_long,
  output logic [31:0]      out_start_cluster,
  output logic             out_is_directory,
  output logic [31:0]      out_entry_size,
  output logic             out_last
);

  localparam int AW = $clog2(NAME_BYTES);
  localparam int PW = fdnd_pkg::POS_W;
  localparam int EW = fdnd_pkg::ENTRY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SUM = 3'd2;
  localparam logic [2:0] S_GATHER = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [EW-1:0]         entry_r, entry_nxt;
  logic [NAME_BYTES-1:0] vbits_r, vbits_nxt;
  logic [AW-1:0]         lnlen_r, lnlen_nxt;
  logic [7:0]            chk_r, chk_nxt;
  logic                  seqv_r, seqv_nxt;
  logic [3:0]            idx_r, idx_nxt;
  logic [PW-1:0]         base_r, base_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         elen_r, elen_nxt;
  logic                  vb_r, vb_nxt;
  logic [63:0]           chunk_r, chunk_nxt;
  logic [3:0]            nb_r, nb_nxt;
  logic                  long_r, long_nxt;
  logic                  eod_r, eod_nxt;
  logic [31:0]           clu_r, clu_nxt;
  logic                  dir_r, dir_nxt;
  logic [31:0]           size_r, size_nxt;
  logic                  last_r, last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;

  logic [7:0] head, attr, sum_byte, pick_byte;
  logic [5:0] ord;
  logic [PW-1:0] ord_m1, slot_base, gpos;
  logic [4:0] coff;
  logic [15:0] gch;
  logic [7:0] sum_step;
  logic [AW-1:0] ptr_inc, sel_len;
  logic use_long;

  logic [3:0] stem_len;
  logic [1:0] ext_len;
  logic [3:0] short_len;
  logic [7:0] sbuf [16];

  fdnd_ram #(
    .WIDTH(8),
    .DEPTH(NAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr_r),
    .rdata(ram_q)
  );

  assign head = entry_r[7:0];
  assign attr = entry_r[95:88];
  assign ord = head[5:0];
  assign ord_m1 = PW'(ord) - PW'(1);
  assign slot_base = (ord_m1 << 3) + (ord_m1 << 2) + ord_m1;
  assign gpos = base_r + PW'(idx_r);
  assign coff = fdnd_pkg::lfn_off(idx_r);
  assign gch = {entry_r[8*(coff+5'd1) +: 8], entry_r[8*coff +: 8]};
  assign sum_byte = entry_r[8*idx_r +: 8];
  assign sum_step = {sum_r[0], sum_r[7:1]} + sum_byte;
  assign use_long = seqv_r && (sum_step == chk_r);
  assign sel_len = use_long ? lnlen_r : AW'(short_len);
  assign ptr_inc = ptr_r + AW'(1);
  assign pick_byte = long_r ? (vb_r ? ram_q : 8'h00) : sbuf[ptr_r[3:0]];

  always_comb begin
    logic [3:0] eidx;
    logic [3:0] pv;
    eidx = 4'd0;
    pv = 4'd0;
    stem_len = 4'd0;
    ext_len = 2'd0;
    for (int i = 0; i < 8; i++) begin
      if (entry_r[8*i +: 8] != fdnd_pkg::ASCII_SPACE) begin
        stem_len = 4'(i + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (entry_r[8*(8+i) +: 8] != fdnd_pkg::ASCII_SPACE) begin
        ext_len = 2'(i + 1);
      end
    end
    short_len = stem_len + ((ext_len != 2'd0) ? ({2'b00, ext_len} + 4'd1) : 4'd0);
    for (int p = 0; p < 16; p++) begin
      pv = 4'(p);
      eidx = pv - stem_len - 4'd1;
      if (pv < stem_len) begin
        sbuf[p] = fdnd_pkg::to_lower(entry_r[8*(p%8) +: 8]);
      end else if (ext_len != 2'd0 && pv == stem_len) begin
        sbuf[p] = fdnd_pkg::ASCII_DOT;
      end else if (ext_len != 2'd0 && pv <= stem_len + {2'b00, ext_len}) begin
        sbuf[p] = fdnd_pkg::to_lower(entry_r[8*(8 + eidx[1:0]) +: 8]);
      end else begin
        sbuf[p] = 8'h00;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    entry_nxt = entry_r;
    vbits_nxt = vbits_r;
    lnlen_nxt = lnlen_r;
    chk_nxt = chk_r;
    seqv_nxt = seqv_r;
    idx_nxt = idx_r;
    base_nxt = base_r;
    sum_nxt = sum_r;
    ptr_nxt = ptr_r;
    elen_nxt = elen_r;
    vb_nxt = vb_r;
    chunk_nxt = chunk_r;
    nb_nxt = nb_r;
    long_nxt = long_r;
    eod_nxt = eod_r;
    clu_nxt = clu_r;
    dir_nxt = dir_r;
    size_nxt = size_r;
    last_nxt = last_r;
    ram_we = 1'b0;
    ram_waddr = gpos[AW-1:0];
    ram_wdata = gch[7:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          entry_nxt = {in_entry_bytes_24_31, in_entry_bytes_16_23,
                       in_entry_bytes_8_15, in_entry_bytes_0_7};
          if (in_new_directory) begin
            seqv_nxt = 1'b0;
          end
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (head == fdnd_pkg::HEAD_END) begin
          eod_nxt = 1'b1;
          chunk_nxt = 64'd0;
          nb_nxt = 4'd0;
          long_nxt = 1'b0;
          clu_nxt = 32'd0;
          dir_nxt = 1'b0;
          size_nxt = 32'd0;
          last_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (head == fdnd_pkg::HEAD_DELETED) begin
          seqv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if (attr == fdnd_pkg::ATTR_LFN) begin
          idx_nxt = 4'd0;
          base_nxt = slot_base;
          if (ord == 6'd0 || ord > fdnd_pkg::ORD_MAX) begin
            seqv_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else if (head[fdnd_pkg::ORD_START_BIT]) begin
            vbits_nxt = '0;
            lnlen_nxt = '0;
            chk_nxt = entry_r[111:104];
            seqv_nxt = 1'b1;
            state_nxt = S_GATHER;
          end else if (entry_r[111:104] != chk_r) begin
            seqv_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_GATHER;
          end
        end else if (attr[fdnd_pkg::ATTR_VOLUME_BIT]) begin
          seqv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if (head == fdnd_pkg::ASCII_DOT &&
                     (entry_r[15:8] == fdnd_pkg::ASCII_SPACE ||
                      (entry_r[15:8] == fdnd_pkg::ASCII_DOT &&
                       entry_r[23:16] == fdnd_pkg::ASCII_SPACE))) begin
          seqv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          eod_nxt = 1'b0;
          clu_nxt = {entry_r[175:168], entry_r[167:160], entry_r[223:216], entry_r[215:208]};
          dir_nxt = attr[fdnd_pkg::ATTR_DIR_BIT];
          size_nxt = entry_r[255:224];
          idx_nxt = 4'd0;
          sum_nxt = 8'd0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = sum_step;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == fdnd_pkg::SUM_LAST_BYTE) begin
          long_nxt = use_long;
          elen_nxt = sel_len;
          seqv_nxt = 1'b0;
          ptr_nxt = '0;
          chunk_nxt = 64'd0;
          if (sel_len == '0) begin
            nb_nxt = 4'd0;
            last_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_GATHER: begin
        if (gpos >= PW'(NAME_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else if (gch == fdnd_pkg::CHAR_NUL || gch == fdnd_pkg::CHAR_PAD) begin
          if (gpos > PW'(lnlen_r)) begin
            lnlen_nxt = gpos[AW-1:0];
          end
          state_nxt = S_IDLE;
        end else begin
          ram_we = 1'b1;
          vbits_nxt[gpos[AW-1:0]] = 1'b1;
          if (gpos + PW'(1) > PW'(lnlen_r)) begin
            lnlen_nxt = AW'(gpos + PW'(1));
          end
          idx_nxt = idx_r + 4'd1;
          if (idx_r == fdnd_pkg::LFN_LAST_CHAR) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        vb_nxt = vbits_r[ptr_r];
        state_nxt = S_PICK;
      end
      S_PICK: begin
        chunk_nxt[8*ptr_r[2:0] +: 8] = pick_byte;
        ptr_nxt = ptr_inc;
        if (ptr_inc == elen_r || ptr_r[2:0] == 3'd7) begin
          nb_nxt = {1'b0, ptr_r[2:0]} + 4'd1;
          last_nxt = (ptr_inc == elen_r);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            chunk_nxt = 64'd0;
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vbits_r <= '0;
      lnlen_r <= '0;
      chk_r <= 8'd0;
      seqv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vbits_r <= vbits_nxt;
      lnlen_r <= lnlen_nxt;
      chk_r <= chk_nxt;
      seqv_r <= seqv_nxt;
    end
    entry_r <= entry_nxt;
    idx_r <= idx_nxt;
    base_r <= base_nxt;
    sum_r <= sum_nxt;
    ptr_r <= ptr_nxt;
    elen_r <= elen_nxt;
    vb_r <= vb_nxt;
    chunk_r <= chunk_nxt;
    nb_r <= nb_nxt;
    long_r <= long_nxt;
    eod_r <= eod_nxt;
    clu_r <= clu_nxt;
    dir_r <= dir_nxt;
    size_r <= size_nxt;
    last_r <= last_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_end_of_directory = eod_r;
  assign out_name_chunk = chunk_r;
  assign out_chunk_bytes = nb_r;
  assign out_name_is_long = long_r;
  assign out_start_cluster = clu_r;
  assign out_is_directory = dir_r;
  assign out_entry_size = size_r;
  assign out_last = last_r;

endmodule
`default_nettype wire
